### sv/nvme_prp_list_builder_top_defines.svh
// Assertion macros used by the PRP list builder core.
`ifndef NVME_PRP_LIST_BUILDER_TOP_DEFINES_SVH
`define NVME_PRP_LIST_BUILDER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked at every rising edge outside reset.
`define NPRP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, during reset too.
`define NPRP_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NPRP_ASSERT(lbl, clk, rst_n, prop, msg)
`define NPRP_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

### sv/nprp_pkg.sv
package nprp_pkg;

  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned PAGE_NUM_W     = 52;
  localparam int unsigned SIZE_W         = 32;
  localparam int unsigned ADDR_W         = 64;
  localparam int unsigned PAGES_LEFT_W   = 21;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_PAIR  = 3'd0,
    KIND_DATA  = 3'd1,
    KIND_CHAIN = 3'd2,
    KIND_TERM  = 3'd3,
    KIND_IDLE  = 3'd4
  } kind_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic [PAGE_NUM_W-1:0] base_page;
    logic [SIZE_W-1:0]     transfer_size;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] first_pointer;
    logic [ADDR_W-1:0] second_pointer;
    logic [ADDR_W-1:0] slot_address;
    logic [ADDR_W-1:0] word_value;
    kind_e             kind;
    logic              last;
  } result_t;

endpackage

### sv/nvme_prp_list_builder_top.sv
// Channel  | Direction | Handshake                 | Payload
// input    | in        | in_valid_i / in_stall_o   | cmd_i, base_page_i, transfer_size_i
// result   | out       | out_valid_o / out_stall_i | first_pointer_o .. last_o
//
// One item is taken per cycle unless the result side stalls; each item passes
// through the input register, whose output feeds the layout logic, which
// updates its state and loads the result register in the same cycle.
// Reset (rst_ni low, asynchronous) clears the layout state and both valid flags.
// A stall with a full result register holds both registers; in_stall_o rises
// only when the input register is full and cannot move on.
module nvme_prp_list_builder_top import nprp_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [PAGE_NUM_W-1:0] base_page_i,
  input  logic [SIZE_W-1:0]     transfer_size_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ADDR_W-1:0]     first_pointer_o,
  output logic [ADDR_W-1:0]     second_pointer_o,
  output logic [ADDR_W-1:0]     slot_address_o,
  output logic [ADDR_W-1:0]     word_value_o,
  output logic [2:0]            kind_o,
  output logic                  last_o
);

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    adv;
  result_t core_res;
  result_t out_res;

  assign in_item.cmd           = cmd_e'(cmd_i);
  assign in_item.base_page     = base_page_i;
  assign in_item.transfer_size = transfer_size_i;

  nprp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .item_i  (in_item),
    .adv_i   (adv),
    .stall_o (in_stall_o),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  nprp_core #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (stage_valid && adv),
    .item_i   (stage_item),
    .result_o (core_res)
  );

  nprp_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (stage_valid),
    .result_i (core_res),
    .stall_i  (out_stall_i),
    .adv_o    (adv),
    .valid_o  (out_valid_o),
    .result_o (out_res)
  );

  assign first_pointer_o  = out_res.first_pointer;
  assign second_pointer_o = out_res.second_pointer;
  assign slot_address_o   = out_res.slot_address;
  assign word_value_o     = out_res.word_value;
  assign kind_o           = out_res.kind;
  assign last_o           = out_res.last;

endmodule

### sv/nprp_in_stage.sv
module nprp_in_stage import nprp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  input  logic  adv_i,
  output logic  stall_o,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // The register holds its item only while the result side cannot take it.
  assign stall_o = valid_q && !adv_i;
  assign load    = !stall_o;
  assign valid_d = load ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### sv/nprp_core.sv
`include "nvme_prp_list_builder_top_defines.svh"
module nprp_core import nprp_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t result_o
);

  localparam int unsigned SHIFT  = $clog2(PAGE_BYTES);
  localparam int unsigned SLOT_W = $clog2(PAGE_BYTES / 8);
  localparam int unsigned SUM_W  = SIZE_W + 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PAGE_BYTES / 8 - 1);
  localparam logic [SUM_W-1:0]  ONE_PAGE  = SUM_W'(PAGE_BYTES);
  localparam logic [SUM_W-1:0]  TWO_PAGES = SUM_W'(2 * PAGE_BYTES);
  localparam logic [SUM_W-1:0]  ROUND_UP  = SUM_W'(PAGE_BYTES - 1);
  localparam logic [SUM_W-1:0]  PL_MAX    =
    {{(SUM_W - PAGES_LEFT_W){1'b0}}, {PAGES_LEFT_W{1'b1}}};

  function automatic logic [ADDR_W-1:0] addr_of(input logic [PAGE_NUM_W-1:0] pg);
    addr_of = {{(ADDR_W - PAGE_NUM_W){1'b0}}, pg} << SHIFT;
  endfunction

  logic                    busy_q, busy_d;
  logic [PAGES_LEFT_W-1:0] pages_left_q, pages_left_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [PAGE_NUM_W-1:0]   list_page_q, list_page_d;
  logic [PAGE_NUM_W-1:0]   next_page_q, next_page_d;

  logic [SUM_W-1:0]        size_ext;
  logic [SUM_W-1:0]        page_count;
  logic [SUM_W-1:0]        list_count;
  logic [PAGES_LEFT_W-1:0] list_count_sat;
  logic [PAGE_NUM_W-1:0]   base_next;
  logic [ADDR_W-1:0]       slot_addr;
  result_t                 res;

  assign size_ext   = {1'b0, item_i.transfer_size};
  assign page_count = (size_ext + ROUND_UP) >> SHIFT;
  // Pages beyond the first one, which the list pointer has to cover.
  assign list_count = page_count - SUM_W'(1);
  assign list_count_sat = (list_count > PL_MAX) ? {PAGES_LEFT_W{1'b1}}
                                                : list_count[PAGES_LEFT_W-1:0];
  assign base_next  = item_i.base_page + PAGE_NUM_W'(1);
  // The slot offset stays below one page, so it fills the zero low bits.
  assign slot_addr  = addr_of(list_page_q)
                    | {{(ADDR_W - SLOT_W - 3){1'b0}}, slot_q, 3'b000};

  always_comb begin
    res          = '0;
    res.kind     = KIND_IDLE;
    busy_d       = busy_q;
    pages_left_d = pages_left_q;
    slot_d       = slot_q;
    list_page_d  = list_page_q;
    next_page_d  = next_page_q;
    case (item_i.cmd)
      CMD_START: begin
        res.kind          = KIND_PAIR;
        res.first_pointer = addr_of(item_i.base_page);
        busy_d            = 1'b0;
        res.last          = 1'b1;
        if (size_ext > ONE_PAGE) begin
          res.second_pointer = addr_of(base_next);
        end
        if (size_ext > TWO_PAGES) begin
          res.last     = 1'b0;
          busy_d       = 1'b1;
          pages_left_d = list_count_sat;
          slot_d       = '0;
          list_page_d  = base_next;
          next_page_d  = item_i.base_page + PAGE_NUM_W'(2);
        end
      end
      CMD_NEXT: begin
        if (busy_q) begin
          res.slot_address = slot_addr;
          if (pages_left_q == '0) begin
            res.kind = KIND_TERM;
            res.last = 1'b1;
            busy_d   = 1'b0;
          end else if (slot_q == SLOT_LAST && pages_left_q > PAGES_LEFT_W'(1)) begin
            // A full list with pages still to come chains to a new list page.
            res.kind       = KIND_CHAIN;
            res.word_value = addr_of(next_page_q);
            list_page_d    = next_page_q;
            next_page_d    = next_page_q + PAGE_NUM_W'(1);
            slot_d         = '0;
          end else begin
            res.kind       = KIND_DATA;
            res.word_value = addr_of(next_page_q);
            next_page_d    = next_page_q + PAGE_NUM_W'(1);
            pages_left_d   = pages_left_q - PAGES_LEFT_W'(1);
            slot_d         = slot_q + SLOT_W'(1);
            // The final entry in the last slot ends the layout without a terminator.
            if (pages_left_q == PAGES_LEFT_W'(1) && slot_q == SLOT_LAST) begin
              res.last = 1'b1;
              busy_d   = 1'b0;
            end
          end
        end
      end
      default: begin
        res.kind = KIND_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pages_left_q <= '0;
      slot_q       <= '0;
      list_page_q  <= '0;
      next_page_q  <= '0;
    end else if (fire_i) begin
      busy_q       <= busy_d;
      pages_left_q <= pages_left_d;
      slot_q       <= slot_d;
      list_page_q  <= list_page_d;
      next_page_q  <= next_page_d;
    end
  end

  assign result_o = res;

  `NPRP_ASSERT(a_last_ends_layout, clk_i, rst_ni, fire_i && res.last |=> !busy_q, "layout still busy after last item")
  `NPRP_ASSERT(a_chain_moves_list, clk_i, rst_ni, fire_i && res.kind == KIND_CHAIN |=> slot_q == '0 && list_page_q == $past(next_page_q), "chain did not open a new list")
  `NPRP_ASSERT(a_data_counts_down, clk_i, rst_ni, fire_i && res.kind == KIND_DATA |=> pages_left_q == $past(pages_left_q) - PAGES_LEFT_W'(1), "data entry did not consume a page")
  `NPRP_ASSERT_NR(a_reset_idle, clk_i, !rst_ni |-> !busy_q && pages_left_q == '0, "layout state not cleared in reset")

endmodule

### sv/nprp_out_stage.sv
module nprp_out_stage import nprp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t result_i,
  input  logic    stall_i,
  output logic    adv_o,
  output logic    valid_o,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  // An empty register, or one being taken this cycle, can load a new item.
  assign adv_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### dv/nvme_prp_list_builder_top_tb.sv
module nvme_prp_list_builder_top_tb;
  import nprp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAGE_BYTES  = PAGE_BYTES_DEF;
  localparam int unsigned LIST_SLOTS  = PAGE_BYTES / 8;
  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned SETTLE      = 10;

  // Keeps its own copy of the layout state and the PRP results it implies.
  class prp_scoreboard;
    bit                      busy;
    logic [PAGES_LEFT_W-1:0] pages_left;
    int unsigned             slot_index;
    logic [PAGE_NUM_W-1:0]   list_page;
    logic [PAGE_NUM_W-1:0]   next_page;
    result_t                 layout_q[$];
    int                      errors;
    int                      kind_seen[5];

    function new();
      busy       = 1'b0;
      pages_left = '0;
      slot_index = 0;
      list_page  = '0;
      next_page  = '0;
      errors     = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function logic [ADDR_W-1:0] page_addr(logic [PAGE_NUM_W-1:0] page);
      return ADDR_W'(page) * ADDR_W'(PAGE_BYTES);
    endfunction

    function void note_item(cmd_e cmd, logic [PAGE_NUM_W-1:0] base,
                            logic [SIZE_W-1:0] size);
      result_t     r;
      logic [63:0] pb;
      logic [63:0] pages;
      r  = '0;
      pb = 64'(PAGE_BYTES);
      if (cmd == CMD_START) begin
        r.kind          = KIND_PAIR;
        r.first_pointer = page_addr(base);
        if (64'(size) <= pb) begin
          busy   = 1'b0;
          r.last = 1'b1;
        end else if (64'(size) <= 2 * pb) begin
          busy             = 1'b0;
          r.second_pointer = page_addr(base + 1'b1);
          r.last           = 1'b1;
        end else begin
          // Pages after the first one, rounded up.
          pages = (64'(size) - 1) / pb;
          if (pages > 64'({PAGES_LEFT_W{1'b1}})) pages = 64'({PAGES_LEFT_W{1'b1}});
          busy             = 1'b1;
          pages_left       = PAGES_LEFT_W'(pages);
          slot_index       = 0;
          list_page        = base + 1'b1;
          next_page        = base + 2'd2;
          r.second_pointer = page_addr(base + 1'b1);
        end
      end else if (!busy) begin
        r.kind = KIND_IDLE;
      end else begin
        r.slot_address = page_addr(list_page) + ADDR_W'(slot_index) * 8;
        if (pages_left == 0) begin
          busy   = 1'b0;
          r.kind = KIND_TERM;
          r.last = 1'b1;
        end else if (slot_index == LIST_SLOTS - 1 && pages_left > 1) begin
          // The last slot of a full list points to the page that holds the next list.
          r.kind       = KIND_CHAIN;
          r.word_value = page_addr(next_page);
          list_page    = next_page;
          next_page    = next_page + 1'b1;
          slot_index   = 0;
        end else begin
          r.kind       = KIND_DATA;
          r.word_value = page_addr(next_page);
          next_page    = next_page + 1'b1;
          pages_left   = pages_left - 1'b1;
          slot_index++;
          if (pages_left == 0 && slot_index >= LIST_SLOTS) begin
            busy   = 1'b0;
            r.last = 1'b1;
          end
        end
      end
      layout_q.insert(layout_q.size(), r);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (got.kind <= KIND_IDLE) kind_seen[got.kind]++;
      if (layout_q.size() == 0) begin
        errors++;
        $display("%0t ns: result with none expected, expected nothing, got kind %0d",
                 $time, got.kind);
        return;
      end
      want = layout_q.pop_front();
      compare_field("first_pointer", want.first_pointer, got.first_pointer);
      compare_field("second_pointer", want.second_pointer, got.second_pointer);
      compare_field("slot_address", want.slot_address, got.slot_address);
      compare_field("word_value", want.word_value, got.word_value);
      compare_field("kind", 64'(want.kind), 64'(got.kind));
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  cmd_i;
  logic [PAGE_NUM_W-1:0] base_page_i;
  logic [SIZE_W-1:0]     transfer_size_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [ADDR_W-1:0]     first_pointer_o;
  logic [ADDR_W-1:0]     second_pointer_o;
  logic [ADDR_W-1:0]     slot_address_o;
  logic [ADDR_W-1:0]     word_value_o;
  logic [2:0]            kind_o;
  logic                  last_o;

  prp_scoreboard sb;
  bit            calm;
  bit            long_hold;
  int unsigned   items_offered;

  nvme_prp_list_builder_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .base_page_i      (base_page_i),
    .transfer_size_i  (transfer_size_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .first_pointer_o  (first_pointer_o),
    .second_pointer_o (second_pointer_o),
    .slot_address_o   (slot_address_o),
    .word_value_o     (word_value_o),
    .kind_o           (kind_o),
    .last_o           (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [PAGE_NUM_W-1:0] pick_page();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '1 - PAGE_NUM_W'($urandom_range(0, 3));
    if (sel == 1) return PAGE_NUM_W'($urandom_range(0, 3));
    return PAGE_NUM_W'({$urandom, $urandom});
  endfunction

  // Called right after a rising edge; returns right after the edge that took the item.
  task automatic drive_item(cmd_e cmd, logic [PAGE_NUM_W-1:0] base, logic [SIZE_W-1:0] size);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    base_page_i     <= base;
    transfer_size_i <= size;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(cmd, base, size);
    items_offered++;
  endtask

  task automatic send_start(logic [PAGE_NUM_W-1:0] base, logic [SIZE_W-1:0] size);
    drive_item(CMD_START, base, size);
  endtask

  // The address and size fields are ignored on a next item, so they carry noise.
  task automatic send_next();
    drive_item(CMD_NEXT, PAGE_NUM_W'({$urandom, $urandom}), $urandom);
  endtask

  task automatic finish_layout();
    while (sb.busy) send_next();
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.layout_q.size() != 0);
  endtask

  task automatic send_pages(int unsigned pages, logic [PAGE_NUM_W-1:0] base);
    logic [SIZE_W-1:0] size;
    size = SIZE_W'(pages * PAGE_BYTES)
         + (($urandom_range(0, 3) == 0) ? SIZE_W'(PAGE_BYTES)
                                        : SIZE_W'($urandom_range(1, PAGE_BYTES)));
    send_start(base, size);
    finish_layout();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{first_pointer:  first_pointer_o,
                        second_pointer: second_pointer_o,
                        slot_address:   slot_address_o,
                        word_value:     word_value_o,
                        kind:           kind_e'(kind_o),
                        last:           last_o});
    end
  end

  // Result side: a random stall ahead of every item, or one long hold on request.
  initial begin
    int unsigned hold;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        hold      = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 5);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #5ms;
    $display("Timed out with %0d results outstanding", sb.layout_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned seq;
    int unsigned pick;
    sb              = new();
    calm            = 1'b0;
    long_hold       = 1'b0;
    items_offered   = 0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    cmd_i           <= CMD_START;
    base_page_i     <= '0;
    transfer_size_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: next while idle, size boundaries, address wrap, restart while busy.
    send_next();
    send_start('0, '0);
    send_start('1, 32'd1);
    send_start(pick_page(), SIZE_W'(PAGE_BYTES));
    send_start('1, SIZE_W'(PAGE_BYTES + 1));
    send_start(pick_page(), SIZE_W'(2 * PAGE_BYTES));
    send_start('1, SIZE_W'(2 * PAGE_BYTES + 1));
    finish_layout();
    send_next();
    send_start(pick_page(), SIZE_W'(3 * PAGE_BYTES));
    send_next();
    send_start(pick_page(), '1);
    send_next();
    send_next();
    send_start('1 - 1'b1, SIZE_W'(5 * PAGE_BYTES + 1));
    finish_layout();

    // A final list filled exactly, then a layout that needs a chained second list.
    send_start(pick_page(), SIZE_W'((LIST_SLOTS + 1) * PAGE_BYTES));
    finish_layout();
    send_pages($urandom_range(LIST_SLOTS + 1, LIST_SLOTS + 8), pick_page());

    seq = 0;
    while (items_offered < ITEM_TARGET) begin
      calm = (seq % 9 == 4);
      if (seq == 10) long_hold = 1'b1;
      if (seq == 25) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_next();
      end else if (pick < 20) begin
        // Abandoned layout: a few list words, then the next start cuts it off.
        send_start(pick_page(), $urandom);
        repeat ($urandom_range(0, 6)) send_next();
      end else if (pick < 30) begin
        send_start(pick_page(), SIZE_W'($urandom_range(0, 2 * PAGE_BYTES + 1)));
      end else begin
        send_pages($urandom_range(2, 30), pick_page());
      end
      seq++;
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.layout_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);

    $display("Covered %0d items: %0d pointer pairs, %0d data words, %0d chain words,",
             items_offered, sb.kind_seen[KIND_PAIR], sb.kind_seen[KIND_DATA],
             sb.kind_seen[KIND_CHAIN]);
    $display("%0d terminators and %0d idle replies, with random stalls on both sides.",
             sb.kind_seen[KIND_TERM], sb.kind_seen[KIND_IDLE]);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
